[src/bdeq_pkg.sv]
`timescale 1ns / 1ps

package bdeq_pkg;

   // Defaults for the top-level parameters
   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed field widths
   localparam int CMD_WIDTH   = 3;
   localparam int COUNT_WIDTH = 5;

   // Capacity register value after reset
   localparam logic [COUNT_WIDTH-1:0] CAP_RESET = 5'd16;

   // Command codes; unused codes act as a query
   localparam logic [CMD_WIDTH-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_QUERY      = 3'd4;

endpackage

[src/bounded_double_ended_queue.sv]
`timescale 1ns / 1ps

// Bounded double-ended queue. Issue one command item (push front, push back,
// pop front, pop back, or query) by raising start while busy is low; the item
// is taken at that clock edge. Exactly one result item follows: rsp_valid is
// high for the single cycle right after the accepting edge, and the receiver
// must take it then, since the block has no way to hold it. A new item may be
// issued in every cycle while busy is low, so the sustained rate is one item
// per clock. That rate is set by the ring store: one write port plus two read
// ports with registered read data, all used in the accepting cycle, with a
// bypass when the pushed entry is the one being read. busy is high only during
// reset and until the first clock edge with reset low. The store is not
// cleared after reset; only live entries are reported. The capacity register
// (csr_*) may be written only while no result is pending; values above DEPTH
// act as DEPTH, zero makes the queue read empty and full at once, and
// lowering it below the current count drops nothing but rejects pushes until
// pops bring the count under it. A push to a full queue or a pop from an
// empty one leaves the queue as it was and raises rsp_rejected. Front and
// back read as zero when the queue is empty.
module bounded_double_ended_queue #(
   parameter int DEPTH      = bdeq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = bdeq_pkg::DATA_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // command channel
   input  logic                             start,
   output logic                             busy,
   input  logic [bdeq_pkg::CMD_WIDTH-1:0]   req_cmd,
   input  logic [DATA_WIDTH-1:0]            req_data_in,
   // result channel
   output logic                             rsp_valid,
   output logic [DATA_WIDTH-1:0]            rsp_front_value,
   output logic [DATA_WIDTH-1:0]            rsp_back_value,
   output logic [bdeq_pkg::COUNT_WIDTH-1:0] rsp_entry_count,
   output logic                             rsp_is_empty,
   output logic                             rsp_is_full,
   output logic                             rsp_rejected,
   // capacity register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bdeq_pkg::COUNT_WIDTH-1:0] csr_wdata
);

   import bdeq_pkg::*;

   // Index widths: AW addresses the store, SW holds an index plus an offset
   // of up to DEPTH before the wrap.
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW = AW + 1;

   // Largest capacity the register can take effect at.
   localparam int CAP_LIMIT = (DEPTH < (1 << COUNT_WIDTH) - 1) ? DEPTH
                                                               : (1 << COUNT_WIDTH) - 1;
   localparam logic [COUNT_WIDTH-1:0] CAP_LIMIT_C = COUNT_WIDTH'(CAP_LIMIT);
   localparam logic [SW-1:0]          DEPTH_S     = SW'(DEPTH);
   localparam logic [AW-1:0]          LAST_IDX    = AW'(DEPTH - 1);

   // Add an offset of at most DEPTH to a ring index and wrap once.
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [SW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + off;
      if (sum >= DEPTH_S) begin
         sum = sum - DEPTH_S;
      end
      return sum[AW-1:0];
   endfunction

   // Ring store
   logic [DATA_WIDTH-1:0]  ring_mem [DEPTH];

   // Queue state
   logic [AW-1:0]          head_ff, head_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] cap_ff;
   logic [COUNT_WIDTH-1:0] eff_cap;
   logic                   busy_ff;

   // Per-item control
   logic                   fire;
   logic                   full_now, empty_now, full_in, rej_in;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr, front_addr, back_addr;

   // Result stage
   logic [DATA_WIDTH-1:0]  rd_front_ff, rd_back_ff, wdata_ff;
   logic                   fwd_front_ff, fwd_back_ff;
   logic                   rsp_valid_ff, rej_ff, full_ff;

   assign fire = start && !busy_ff;

   // Work out the new ends and the store write for the item at the port.
   always_comb begin
      eff_cap   = (cap_ff > CAP_LIMIT_C) ? CAP_LIMIT_C : cap_ff;
      full_now  = count_ff >= eff_cap;
      empty_now = count_ff == '0;

      head_in  = head_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = head_ff;
      rej_in   = 1'b0;

      case (req_cmd)
         CMD_PUSH_FRONT: begin
            if (full_now) begin
               rej_in = 1'b1;
            end else begin
               // step the head back one slot and store there
               head_in  = (head_ff == '0) ? LAST_IDX : head_ff - AW'(1);
               wr_en    = 1'b1;
               wr_addr  = head_in;
               count_in = count_ff + COUNT_WIDTH'(1);
            end
         end
         CMD_PUSH_BACK: begin
            if (full_now) begin
               rej_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = wrap_add(head_ff, SW'(count_ff));
               count_in = count_ff + COUNT_WIDTH'(1);
            end
         end
         CMD_POP_FRONT: begin
            if (empty_now) begin
               rej_in = 1'b1;
            end else begin
               head_in  = (head_ff == LAST_IDX) ? '0 : head_ff + AW'(1);
               count_in = count_ff - COUNT_WIDTH'(1);
            end
         end
         CMD_POP_BACK: begin
            if (empty_now) begin
               rej_in = 1'b1;
            end else begin
               count_in = count_ff - COUNT_WIDTH'(1);
            end
         end
         default: begin
            // query and unused codes change nothing
         end
      endcase

      // Ends after the item; the back address is junk when the queue empties,
      // and the result then masks it to zero.
      front_addr = head_in;
      back_addr  = wrap_add(head_in, SW'(count_in) - SW'(1));
      full_in    = count_in >= eff_cap;
   end

   // Store: one write and two registered reads in the accepting cycle. The
   // reads see the old contents, so a pushed entry is bypassed below.
   always_ff @(posedge clock) begin
      if (fire && wr_en) begin
         ring_mem[wr_addr] <= req_data_in;
      end
      if (fire) begin
         rd_front_ff <= ring_mem[front_addr];
         rd_back_ff  <= ring_mem[back_addr];
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         head_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= fire;
         if (fire) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   // Result payload; hold the pushed item for the bypass.
   always_ff @(posedge clock) begin
      if (fire) begin
         wdata_ff     <= req_data_in;
         fwd_front_ff <= wr_en && (wr_addr == front_addr);
         fwd_back_ff  <= wr_en && (wr_addr == back_addr);
         rej_ff       <= rej_in;
         full_ff      <= full_in;
      end
   end

   // Drive the result; count_ff already holds the count after the item.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_is_empty    = count_ff == '0;
   assign rsp_is_full     = full_ff;
   assign rsp_rejected    = rej_ff;
   assign rsp_front_value = (count_ff == '0) ? '0 : (fwd_front_ff ? wdata_ff : rd_front_ff);
   assign rsp_back_value  = (count_ff == '0) ? '0 : (fwd_back_ff ? wdata_ff : rd_back_ff);

   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;

endmodule

[src/bdeq_checker.sv]
`timescale 1ns / 1ps

module bdeq_checker #(
   parameter int DATA_WIDTH = bdeq_pkg::DATA_WIDTH_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic [bdeq_pkg::CMD_WIDTH-1:0]   req_cmd,
   input logic                             rsp_valid,
   input logic [DATA_WIDTH-1:0]            rsp_front_value,
   input logic [DATA_WIDTH-1:0]            rsp_back_value,
   input logic [bdeq_pkg::COUNT_WIDTH-1:0] rsp_entry_count,
   input logic                             rsp_is_empty,
   input logic                             rsp_is_full,
   input logic                             rsp_rejected
);

   import bdeq_pkg::*;

   // Every accepted item yields a result in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted item gave no result");

   // No result without an item accepted the cycle before.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy))
      else $error("result without an accepted item");

   // Empty queue shows zero count and zero ends.
   a_empty_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)) &&
                    (!rsp_is_empty || (rsp_front_value == '0 && rsp_back_value == '0)))
      else $error("empty mark, count and ends disagree");

   // A rejection means a full push or an empty pop.
   a_reject_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rejected) |-> (rsp_is_empty || rsp_is_full))
      else $error("rejected item with room and entries");

   // Queries and unused codes are never rejected.
   a_query_not_rejected: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_cmd) != CMD_PUSH_FRONT && $past(req_cmd) != CMD_PUSH_BACK &&
       $past(req_cmd) != CMD_POP_FRONT && $past(req_cmd) != CMD_POP_BACK) |-> !rsp_rejected)
      else $error("query item flagged as rejected");

endmodule

bind bounded_double_ended_queue bdeq_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_bdeq_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_cmd         (req_cmd),
   .rsp_valid       (rsp_valid),
   .rsp_front_value (rsp_front_value),
   .rsp_back_value  (rsp_back_value),
   .rsp_entry_count (rsp_entry_count),
   .rsp_is_empty    (rsp_is_empty),
   .rsp_is_full     (rsp_is_full),
   .rsp_rejected    (rsp_rejected)
);

[verif/bounded_double_ended_queue_tb.sv]
`timescale 1ns / 1ps

module bounded_double_ended_queue_tb;
   import bdeq_pkg::*;

   localparam int DEPTH       = DEPTH_DEF;
   localparam int DATA_WIDTH  = DATA_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 100000;
   localparam int REPORT_MAX  = 10;
   localparam int SETTLE      = 4;

   // One result item as the block reports it
   typedef struct packed {
      logic [DATA_WIDTH-1:0]  front_value;
      logic [DATA_WIDTH-1:0]  back_value;
      logic [COUNT_WIDTH-1:0] entry_count;
      logic                   is_empty;
      logic                   is_full;
      logic                   rejected;
   } deq_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [CMD_WIDTH-1:0]   req_cmd = CMD_QUERY;
   logic [DATA_WIDTH-1:0]  req_data_in = '0;
   logic                   rsp_valid;
   logic [DATA_WIDTH-1:0]  rsp_front_value;
   logic [DATA_WIDTH-1:0]  rsp_back_value;
   logic [COUNT_WIDTH-1:0] rsp_entry_count;
   logic                   rsp_is_empty;
   logic                   rsp_is_full;
   logic                   rsp_rejected;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [COUNT_WIDTH-1:0] csr_wdata = '0;

   // Shadow copy of the queue: ring contents, head pointer, fill level, capacity
   logic [DATA_WIDTH-1:0]  shadow_ring [DEPTH];
   int                     shadow_head = 0;
   int                     shadow_count = 0;
   logic [COUNT_WIDTH-1:0] shadow_capacity = CAP_RESET;

   deq_result_type         expected_results [$];
   int                     mismatch_count = 0;
   int                     cycle_count = 0;
   bit                     gap_free = 1'b0;

   bounded_double_ended_queue u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_data_in     (req_data_in),
      .rsp_valid       (rsp_valid),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_rejected    (rsp_rejected),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bail out if the block stops answering
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Apply one command to the shadow queue and return the result it must give.
   // Pushes land before head (front) or after the last live entry (back);
   // pops only move head or shrink the count, so the store is never cleared.
   function automatic deq_result_type apply_command(logic [CMD_WIDTH-1:0] cmd,
                                                    logic [DATA_WIDTH-1:0] value);
      deq_result_type res;
      int             limit;
      bit             was_full;
      bit             was_empty;
      limit     = (shadow_capacity > DEPTH) ? DEPTH : int'(shadow_capacity);
      was_full  = shadow_count >= limit;
      was_empty = shadow_count == 0;
      res.rejected = 1'b0;
      case (cmd)
         CMD_PUSH_FRONT: begin
            if (was_full) begin
               res.rejected = 1'b1;
            end else begin
               shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
               shadow_ring[shadow_head] = value;
               shadow_count++;
            end
         end
         CMD_PUSH_BACK: begin
            if (was_full) begin
               res.rejected = 1'b1;
            end else begin
               shadow_ring[(shadow_head + shadow_count) % DEPTH] = value;
               shadow_count++;
            end
         end
         CMD_POP_FRONT: begin
            if (was_empty) begin
               res.rejected = 1'b1;
            end else begin
               shadow_head = (shadow_head + 1) % DEPTH;
               shadow_count--;
            end
         end
         CMD_POP_BACK: begin
            if (was_empty) begin
               res.rejected = 1'b1;
            end else begin
               shadow_count--;
            end
         end
         // query and the spare codes leave the queue alone
         default: ;
      endcase
      if (shadow_count == 0) begin
         res.front_value = '0;
         res.back_value  = '0;
      end else begin
         res.front_value = shadow_ring[shadow_head];
         res.back_value  = shadow_ring[(shadow_head + shadow_count - 1) % DEPTH];
      end
      res.entry_count = COUNT_WIDTH'(shadow_count);
      res.is_empty    = shadow_count == 0;
      res.is_full     = shadow_count >= limit;
      return res;
   endfunction

   // Send one command item; record its expected result at the accepting edge.
   // Leave start high on return so a back-to-back item needs no idle gap.
   task automatic issue_command(input logic [CMD_WIDTH-1:0] cmd,
                                input logic [DATA_WIDTH-1:0] value);
      int gap;
      gap = gap_free ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start       <= 1'b1;
      req_cmd     <= cmd;
      req_data_in <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_results.push_back(apply_command(cmd, value));
   endtask

   // Drop start and hold until every outstanding result has come back
   task automatic wait_for_results;
      @(negedge clock);
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Write the capacity register with the queue idle
   task automatic write_capacity(input logic [COUNT_WIDTH-1:0] value);
      wait_for_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_capacity = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly random words, with the all-zero and all-one patterns mixed in
   function automatic logic [DATA_WIDTH-1:0] pick_data();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return DATA_WIDTH'($urandom);
      endcase
   endfunction

   task automatic check_field(input string name, input logic [DATA_WIDTH-1:0] want,
                              input logic [DATA_WIDTH-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("%0t: %s expected %h, got %h", $realtime, name, want, got);
      end
   endtask

   // Compare every result item against the oldest expectation
   always @(posedge clock) begin : result_check
      deq_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("%0t: result item with nothing expected", $realtime);
         end else begin
            want = expected_results.pop_front();
            check_field("front_value", want.front_value, rsp_front_value);
            check_field("back_value", want.back_value, rsp_back_value);
            check_field("entry_count", DATA_WIDTH'(want.entry_count),
                        DATA_WIDTH'(rsp_entry_count));
            check_field("is_empty", DATA_WIDTH'(want.is_empty), DATA_WIDTH'(rsp_is_empty));
            check_field("is_full", DATA_WIDTH'(want.is_full), DATA_WIDTH'(rsp_is_full));
            check_field("rejected", DATA_WIDTH'(want.rejected), DATA_WIDTH'(rsp_rejected));
         end
      end
   end

   // Both ends, wrap of head below zero, spare codes, pops on an empty queue
   task automatic test_end_cases;
      issue_command(CMD_QUERY, '1);
      issue_command(CMD_PUSH_FRONT, '1);
      issue_command(CMD_PUSH_BACK, '0);
      issue_command(CMD_PUSH_FRONT, {(DATA_WIDTH / 2){2'b10}});
      issue_command(CMD_PUSH_BACK, {(DATA_WIDTH / 2){2'b01}});
      for (int code = CMD_QUERY + 1; code < (1 << CMD_WIDTH); code++)
         issue_command(CMD_WIDTH'(code), pick_data());
      issue_command(CMD_POP_BACK, pick_data());
      issue_command(CMD_POP_FRONT, pick_data());
      issue_command(CMD_POP_FRONT, pick_data());
      // last pop empties the queue
      issue_command(CMD_POP_BACK, pick_data());
      issue_command(CMD_POP_FRONT, pick_data());
      issue_command(CMD_POP_BACK, pick_data());
   endtask

   // A single slot: one push fills it, pushes at either end bounce
   task automatic test_capacity_one;
      write_capacity(COUNT_WIDTH'(1));
      issue_command(CMD_PUSH_BACK, pick_data());
      issue_command(CMD_PUSH_FRONT, pick_data());
      issue_command(CMD_PUSH_BACK, pick_data());
      issue_command(CMD_POP_FRONT, pick_data());
   endtask

   // Zero capacity reads empty and full together and refuses every push
   task automatic test_capacity_zero;
      write_capacity('0);
      issue_command(CMD_PUSH_FRONT, pick_data());
      issue_command(CMD_PUSH_BACK, pick_data());
      issue_command(CMD_QUERY, pick_data());
   endtask

   // One random stretch at a given capacity; push_pct steers the fill level
   task automatic run_phase(input logic [COUNT_WIDTH-1:0] cap, input int push_pct,
                            input bit no_gaps, input int n_items);
      int                   roll;
      logic [CMD_WIDTH-1:0] cmd;
      write_capacity(cap);
      gap_free = no_gaps;
      for (int i = 0; i < n_items; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < push_pct)
            cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
         else if (roll < 92)
            cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
         else
            cmd = CMD_WIDTH'($urandom_range(CMD_QUERY, (1 << CMD_WIDTH) - 1));
         issue_command(cmd, pick_data());
      end
      gap_free = 1'b0;
   endtask

   // Queue is never drained between phases, so a lowered capacity meets a
   // deeper queue; the capacity values cover zero, one, DEPTH and above it
   task automatic test_random_phases;
      run_phase(CAP_RESET, 85, 1'b0, 110);
      run_phase(COUNT_WIDTH'(4), 25, 1'b1, 110);
      run_phase('1, 60, 1'b0, 110);
      run_phase(COUNT_WIDTH'(1), 50, 1'b0, 100);
      run_phase('0, 50, 1'b1, 60);
      run_phase(COUNT_WIDTH'(17), 75, 1'b0, 110);
      run_phase(COUNT_WIDTH'(6), 20, 1'b0, 110);
      run_phase(CAP_RESET, 55, 1'b1, 120);
      run_phase(COUNT_WIDTH'(2), 50, 1'b0, 100);
      run_phase(COUNT_WIDTH'(12), 70, 1'b0, 110);
      run_phase(COUNT_WIDTH'(3), 30, 1'b1, 100);
      run_phase(CAP_RESET, 45, 1'b0, 120);
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_end_cases();
      test_capacity_one();
      test_capacity_zero();
      test_random_phases();

      // Let the last results land, then settle before judging
      wait_for_results();
      repeat (SETTLE) @(posedge clock);
      mismatch_count += expected_results.size();
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[bounded_double_ended_queue.f]
src/bdeq_pkg.sv
src/bounded_double_ended_queue.sv
src/bdeq_checker.sv
verif/bounded_double_ended_queue_tb.sv
